FILE: rtl/core/nctm_pkg.sv
// Shared types and codes for the nearest color table match block.
package nctm_pkg;

   localparam logic [1:0] OP_APPEND  = 2'd0;
   localparam logic [1:0] OP_NEAREST = 2'd1;
   localparam logic [1:0] OP_LOOKUP  = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int SQ_W   = 24;
   localparam int DIST_W = 26;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         label_code;
      logic signed [11:0] lab_l;
      logic signed [11:0] lab_a;
      logic signed [11:0] lab_b;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [7:0]         match_label;
      logic signed [11:0] match_l;
      logic signed [11:0] match_a;
      logic signed [11:0] match_b;
   } rsp_type;

   typedef struct packed {
      logic [7:0]         label;
      logic signed [11:0] l;
      logic signed [11:0] a;
      logic signed [11:0] b;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic append;
      logic scan_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       scan_last;
      logic       pipe_busy;
   } sts_type;

endpackage

FILE: rtl/core/nctm_ctrl.sv
// Sequencing state machine for the nearest color table match block.
module nctm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  nctm_pkg::sts_type sts,
   output nctm_pkg::cmd_type cmd
);
   import nctm_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECODE = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_DRAIN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_APPEND: begin
                  cmd.append = 1'b1;
                  cmd.emit   = 1'b1;
                  state_in   = S_IDLE;
               end
               OP_NEAREST, OP_LOOKUP: begin
                  if (sts.empty) begin
                     cmd.emit = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/core/nctm_dpath.sv
// Table memory, distance pipeline and result register of the color match block.
module nctm_dpath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  nctm_pkg::req_type req_payload,
   input  nctm_pkg::cmd_type cmd,
   output nctm_pkg::sts_type sts,
   output logic              rsp_strobe,
   output nctm_pkg::rsp_type rsp_payload
);
   import nctm_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   entry_type             mem [TABLE_DEPTH];

   req_type               req_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]      addr_ff;
   entry_type             rd_data_ff;
   logic                  p1_vld_ff;
   logic                  p1_first_ff;
   entry_type             p2_entry_ff;
   logic                  p2_vld_ff;
   logic                  p2_first_ff;
   logic                  p2_hit_ff;
   logic [SQ_W-1:0]       sq_l_ff;
   logic [SQ_W-1:0]       sq_a_ff;
   logic [SQ_W-1:0]       sq_b_ff;
   entry_type             best_ff;
   entry_type             zero_ff;
   logic [DIST_W-1:0]     best_d_ff;
   logic                  found_ff;
   rsp_type               rsp_ff;
   logic                  strobe_ff;

   logic                  full;
   logic                  empty;
   logic                  write_en;
   entry_type             new_entry;
   logic signed [12:0]    diff_l;
   logic signed [12:0]    diff_a;
   logic signed [12:0]    diff_b;
   logic signed [25:0]    prod_l;
   logic signed [25:0]    prod_a;
   logic signed [25:0]    prod_b;
   logic [DIST_W-1:0]     cand_dist;
   rsp_type               rsp_in;

   assign full      = (count_ff == CNT_W'(TABLE_DEPTH));
   assign empty     = (count_ff == '0);
   assign write_en  = cmd.append && !full;

   assign new_entry.label = req_ff.label_code;
   assign new_entry.l     = req_ff.lab_l;
   assign new_entry.a     = req_ff.lab_a;
   assign new_entry.b     = req_ff.lab_b;

   assign sts.op        = req_ff.op;
   assign sts.empty     = empty;
   assign sts.scan_last = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);
   assign sts.pipe_busy = p1_vld_ff || p2_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[count_ff[IDX_W-1:0]] <= new_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         addr_ff   <= '0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         if (write_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.capture) begin
            addr_ff <= '0;
         end else if (cmd.scan_step) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
         p1_vld_ff <= cmd.scan_step;
         p2_vld_ff <= p1_vld_ff;
         if (cmd.capture) begin
            found_ff <= 1'b0;
         end else if (p2_vld_ff && (req_ff.op == OP_LOOKUP) && p2_hit_ff) begin
            found_ff <= 1'b1;
         end
         strobe_ff <= cmd.emit;
      end
   end

   // Squared differences of the query against the entry just read.
   assign diff_l = $signed({req_ff.lab_l[11], req_ff.lab_l}) -
                   $signed({rd_data_ff.l[11], rd_data_ff.l});
   assign diff_a = $signed({req_ff.lab_a[11], req_ff.lab_a}) -
                   $signed({rd_data_ff.a[11], rd_data_ff.a});
   assign diff_b = $signed({req_ff.lab_b[11], req_ff.lab_b}) -
                   $signed({rd_data_ff.b[11], rd_data_ff.b});
   assign prod_l = diff_l * diff_l;
   assign prod_a = diff_a * diff_a;
   assign prod_b = diff_b * diff_b;

   always_ff @(posedge clock) begin
      p1_first_ff <= (addr_ff == '0);
      p2_first_ff <= p1_first_ff;
      p2_entry_ff <= rd_data_ff;
      p2_hit_ff   <= (rd_data_ff.label == req_ff.label_code);
      sq_l_ff     <= prod_l[SQ_W-1:0];
      sq_a_ff     <= prod_a[SQ_W-1:0];
      sq_b_ff     <= prod_b[SQ_W-1:0];
   end

   assign cand_dist = {2'b00, sq_l_ff} + {2'b00, sq_a_ff} + {2'b00, sq_b_ff};

   // For nearest the first entry becomes the candidate; later ones replace it only
   // when strictly closer (ties keep the lowest index); lookup keeps the first hit.
   always_ff @(posedge clock) begin
      if (p2_vld_ff) begin
         if (p2_first_ff) begin
            zero_ff <= p2_entry_ff;
         end
         if (req_ff.op == OP_NEAREST) begin
            if (p2_first_ff || (cand_dist < best_d_ff)) begin
               best_ff   <= p2_entry_ff;
               best_d_ff <= cand_dist;
            end
         end else if (!found_ff && p2_hit_ff) begin
            best_ff <= p2_entry_ff;
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      case (req_ff.op)
         OP_APPEND: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status      = ST_OK;
               rsp_in.match_label = new_entry.label;
               rsp_in.match_l     = new_entry.l;
               rsp_in.match_a     = new_entry.a;
               rsp_in.match_b     = new_entry.b;
            end
         end
         OP_NEAREST, OP_LOOKUP: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if ((req_ff.op == OP_LOOKUP) && !found_ff) begin
               rsp_in.status      = ST_NOT_FOUND;
               rsp_in.match_label = zero_ff.label;
               rsp_in.match_l     = zero_ff.l;
               rsp_in.match_a     = zero_ff.a;
               rsp_in.match_b     = zero_ff.b;
            end else begin
               rsp_in.status      = ST_OK;
               rsp_in.match_label = best_ff.label;
               rsp_in.match_l     = best_ff.l;
               rsp_in.match_a     = best_ff.a;
               rsp_in.match_b     = best_ff.b;
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/nearest_color_table_match.sv
// Top level of the nearest color table match block.
//
//   Channel    Handshake                 Payload
//   request    start, busy               req_payload (op, label, Lab coordinates)
//   result     rsp_strobe                rsp_payload (status, label, Lab coordinates)
//
// A request is taken when start is high and busy is low; its result appears on
// rsp_strobe for one cycle. Append goes from acceptance via the decode state to
// the result register, and a query on an empty table the same. Nearest and lookup
// add a walk of the table memory at one entry per cycle over the N stored entries,
// followed by the read and distance stages. An unused op code gives no result and
// holds busy for one cycle. Reset is synchronous and empties the table at once.
module nearest_color_table_match #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nctm_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output nctm_pkg::rsp_type rsp_payload
);
   import nctm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   nctm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   nctm_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted request did not make the block busy.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("Result strobe without a request in progress.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two results in consecutive cycles.");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step || sts.pipe_busy) |-> busy)
      else $error("Table walk active while the block is idle.");
`endif

endmodule
